// ----- design/pblit_pkg.sv -----
// Shared types, register indexes and colour packing functions of the pixel blitter.
package pblit_pkg;

    // Screen geometry: two pixels share one work-memory word.
    localparam int SCR_COLS  = 512;
    localparam int SCR_ROWS  = 256;
    localparam int MEM_WORDS = SCR_COLS * SCR_ROWS / 2;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Command queue between the walker and the pixel engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [2:0] CFG_DRAW_X       = 3'd0;
    localparam logic [2:0] CFG_DRAW_Y       = 3'd1;
    localparam logic [2:0] CFG_SIZE_X       = 3'd2;
    localparam logic [2:0] CFG_SIZE_Y       = 3'd3;
    localparam logic [2:0] CFG_MODE_FLAGS   = 3'd4;
    localparam logic [2:0] CFG_PALETTE_LOW  = 3'd5;
    localparam logic [2:0] CFG_PALETTE_HIGH = 3'd6;

    // Transparent codes.
    localparam logic [7:0]  PAL_TRANSPARENT = 8'hff;
    localparam logic [15:0] COL_TRANSPARENT = 16'hffff;

    // What the pixel engine does with a command.
    typedef enum logic [1:0] {
        OP_PALETTE = 2'd0,
        OP_FILL    = 2'd1,
        OP_MERGE   = 2'd2
    } pblit_op_t;

    typedef struct packed {
        logic [7:0] rom_byte;
        logic       start_req;
    } pblit_in_t;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] pixel_color;
        logic        last_of_item;
    } pblit_out_t;

    // One drawing command: a pair of pixels at columns {col_pair, x odd flag}.
    typedef struct packed {
        logic [7:0] rom_byte;
        logic [7:0] col_pair;
        logic [7:0] row;
        logic       screen_flip;
        logic       flip_x;
        pblit_op_t  op;
    } pblit_cmd_t;

    typedef struct packed {
        logic       valid;
        pblit_cmd_t cmd;
    } pblit_push_t;

    // Byte bbgggrrr to bb000ggg00rrr000.
    function automatic logic [15:0] pack_high(input logic [7:0] p);
        return {p[7:6], 3'b000, p[5:3], 2'b00, p[2:0], 3'b000};
    endfunction

    // Byte bbbggrrr to 00bbb000gg000rrr.
    function automatic logic [15:0] pack_low(input logic [7:0] p);
        return {2'b00, p[7:5], 3'b000, p[4:3], 3'b000, p[2:0]};
    endfunction

endpackage

// ----- design/pblit_front.sv -----
// Front end of the blitter: geometry registers, block walk and command generation.
module pblit_front
    import pblit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pblit_in_t   in_data,
    input  logic        space_ok,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output pblit_push_t push
);

    logic [7:0] org_x_reg, org_y_reg, size_x_reg, size_y_reg, lat_size_x_reg;
    logic [4:0] mode_reg, lat_mode_reg;
    logic [8:0] col_off_reg, cols_left_reg, row_off_reg, rows_left_reg;

    logic [4:0] lm;
    logic [7:0] lsx, ox, oy, u, v;
    logic [8:0] col0, cl0, row0, rl0, col1, cl1, row1, rl1;
    logic       accept, active;

    assign in_ready = space_ok;
    assign accept   = in_valid && in_ready;

    // Start handling and the next walk position.
    always_comb
    begin
        lm   = lat_mode_reg;
        lsx  = lat_size_x_reg;
        ox   = org_x_reg;
        oy   = org_y_reg;
        col0 = col_off_reg;
        cl0  = cols_left_reg;
        row0 = row_off_reg;
        rl0  = rows_left_reg;
        if (in_data.start_req)
        begin
            lm  = mode_reg;
            lsx = size_x_reg;
            if (mode_reg[0])
            begin
                ox   = org_x_reg - {size_x_reg[6:0], 1'b0};
                col0 = {1'b0, size_x_reg};
                cl0  = 9'd256 - {1'b0, size_x_reg};
            end
            else
            begin
                ox   = org_x_reg - size_x_reg;
                col0 = '0;
                cl0  = {1'b0, size_x_reg} + 9'd1;
            end
            if (mode_reg[1])
            begin
                oy   = org_y_reg - {size_y_reg[6:0], 1'b0} - 8'd1;
                row0 = {1'b0, size_y_reg};
                rl0  = 9'd256 - {1'b0, size_y_reg};
            end
            else
            begin
                oy   = org_y_reg - size_y_reg - 8'd1;
                row0 = '0;
                rl0  = {1'b0, size_y_reg} + 9'd1;
            end
        end
        active = (rl0 != 9'd0);
        u      = ox + col0[7:0];
        v      = oy + row0[7:0];

        // Step along the row, and on to the next row at its end.
        col1 = lm[0] ? (col0 - 9'd1) : (col0 + 9'd1);
        cl1  = cl0 - 9'd1;
        row1 = row0;
        rl1  = rl0;
        if (cl1 == 9'd0)
        begin
            rl1  = rl0 - 9'd1;
            row1 = lm[1] ? (row0 - 9'd1) : (row0 + 9'd1);
            col1 = lm[0] ? {1'b0, lsx} : 9'd0;
            cl1  = lm[0] ? (9'd256 - {1'b0, lsx}) : ({1'b0, lsx} + 9'd1);
        end
    end

    // Command for the pixel engine; the screen flip mirrors the pair and the row.
    always_comb
    begin
        push.valid           = accept && active;
        push.cmd.rom_byte    = in_data.rom_byte;
        push.cmd.col_pair    = lm[2] ? ~u : u;
        push.cmd.row         = lm[2] ? ~v : v;
        push.cmd.screen_flip = lm[2];
        push.cmd.flip_x      = lm[0];
        if (!lm[3])
        begin
            push.cmd.op = OP_PALETTE;
        end
        else if (lm[4])
        begin
            push.cmd.op = OP_MERGE;
        end
        else
        begin
            push.cmd.op = OP_FILL;
        end
    end

    // Walk state, latched blit settings and geometry registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg      <= 8'hff;
            org_y_reg      <= 8'hff;
            size_x_reg     <= '0;
            size_y_reg     <= '0;
            mode_reg       <= '0;
            lat_mode_reg   <= '0;
            lat_size_x_reg <= '0;
            col_off_reg    <= '0;
            cols_left_reg  <= '0;
            row_off_reg    <= '0;
            rows_left_reg  <= '0;
        end
        else
        begin
            if (accept && in_data.start_req)
            begin
                lat_mode_reg   <= lm;
                lat_size_x_reg <= lsx;
                org_x_reg      <= ox;
                org_y_reg      <= oy;
            end
            if (accept && active)
            begin
                col_off_reg   <= col1;
                cols_left_reg <= cl1;
                row_off_reg   <= row1;
                rows_left_reg <= rl1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DRAW_X:     org_x_reg  <= cfg_data[7:0] ^ 8'hff;
                    CFG_DRAW_Y:     org_y_reg  <= cfg_data[7:0] ^ 8'hff;
                    CFG_SIZE_X:     size_x_reg <= cfg_data[7:0];
                    CFG_SIZE_Y:     size_y_reg <= cfg_data[7:0];
                    CFG_MODE_FLAGS: mode_reg   <= cfg_data[4:0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

// ----- design/pblit_queue.sv -----
// Short command queue between the walker and the pixel engine.
module pblit_queue
    import pblit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pblit_push_t push,
    output logic        has_space,
    output logic        head_valid,
    output pblit_cmd_t  head,
    input  logic        pop
);

    pblit_cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign has_space  = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && has_space;
    assign do_pop     = pop && head_valid;

    // Occupancy count.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ----- design/pblit_back.sv -----
// Pixel engine: work memory with its clearing pass, palette, colour merge and output register.
module pblit_back
    import pblit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  pblit_cmd_t  head,
    output logic        pop,
    output logic        clearing,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pblit_out_t  out_data
);

    // Work memory: one word holds an even pixel (low half) and an odd pixel (high half).
    logic [31:0]       mem [MEM_WORDS];
    logic [31:0]       rd_reg;
    logic [MEM_AW-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic              mem_we, mem_re;

    logic [MEM_AW-1:0] clr_addr_reg;
    logic              clr_active_reg;

    logic [63:0] pal_lo_reg, pal_hi_reg;

    pblit_cmd_t b_cmd_reg;
    logic       b_valid_reg, b_valid_next, b_phase_reg, b_phase_next;
    pblit_out_t out_reg;
    logic       out_valid_reg, out_valid_next;

    logic [3:0]  nib1, nib2;
    logic [7:0]  p1, p2;
    logic [15:0] w1, w2, c1, c2;
    logic        t1, t2, out_can, emit, retire, sel2, issue, b_can_load;

    assign clearing = clr_active_reg;

    function automatic logic [7:0] pal_entry(input logic [3:0] n, input logic [63:0] lo,
                                             input logic [63:0] hi);
        logic [63:0] bank;
        bank = n[3] ? hi : lo;
        return bank[{n[2:0], 3'b000} +: 8];
    endfunction

    // Colours of the two pixels of the command in the pixel stage.
    always_comb
    begin
        nib1 = b_cmd_reg.flip_x ? b_cmd_reg.rom_byte[7:4] : b_cmd_reg.rom_byte[3:0];
        nib2 = b_cmd_reg.flip_x ? b_cmd_reg.rom_byte[3:0] : b_cmd_reg.rom_byte[7:4];
        p1   = pal_entry(nib1, pal_lo_reg, pal_hi_reg);
        p2   = pal_entry(nib2, pal_lo_reg, pal_hi_reg);
        w1   = b_cmd_reg.screen_flip ? rd_reg[31:16] : rd_reg[15:0];
        w2   = b_cmd_reg.screen_flip ? rd_reg[15:0] : rd_reg[31:16];
        case (b_cmd_reg.op)
            OP_MERGE:
            begin
                c1 = pack_low(b_cmd_reg.rom_byte) | w1;
                c2 = pack_low(b_cmd_reg.rom_byte) | w2;
                t1 = (c1 != COL_TRANSPARENT);
                t2 = (c2 != COL_TRANSPARENT);
            end
            OP_PALETTE:
            begin
                c1 = pack_high(p1);
                c2 = pack_high(p2);
                t1 = (p1 != PAL_TRANSPARENT);
                t2 = (p2 != PAL_TRANSPARENT);
            end
            default:
            begin
                c1 = '0;
                c2 = '0;
                t1 = 1'b0;
                t2 = 1'b0;
            end
        endcase
    end

    // Emission: the first visible pixel, then the second one on a later beat.
    always_comb
    begin
        out_can    = !out_valid_reg || out_ready;
        sel2       = b_phase_reg || !t1;
        emit       = b_valid_reg && out_can && (b_phase_reg || t1 || t2);
        retire     = b_valid_reg && out_can && (b_phase_reg || !(t1 && t2));
        b_can_load = !b_valid_reg || retire;
        issue      = head_valid && !clr_active_reg && b_can_load;
        pop        = issue;

        b_valid_next = b_valid_reg;
        b_phase_next = b_phase_reg;
        if (retire)
        begin
            b_valid_next = 1'b0;
            b_phase_next = 1'b0;
        end
        else if (emit)
        begin
            b_phase_next = 1'b1;
        end
        if (issue && head.op != OP_FILL)
        begin
            b_valid_next = 1'b1;
            b_phase_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Single memory port: clearing pass, fill write, or read for merge and palette commands.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {head.row, head.col_pair};
        mem_wdata = {pack_high(head.rom_byte), pack_high(head.rom_byte)};
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (issue)
        begin
            mem_we = (head.op == OP_FILL);
            mem_re = (head.op != OP_FILL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_addr];
        end
    end

    // Control state: clearing pass, pixel stage and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            b_valid_reg    <= 1'b0;
            b_phase_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pal_lo_reg     <= '0;
            pal_hi_reg     <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {MEM_AW{1'b1}})
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            b_valid_reg   <= b_valid_next;
            b_phase_reg   <= b_phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PALETTE_LOW:  pal_lo_reg <= cfg_data;
                    CFG_PALETTE_HIGH: pal_hi_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_cmd_reg <= head;
        end
        if (emit)
        begin
            out_reg.pixel_x      <= {b_cmd_reg.col_pair, sel2 ^ b_cmd_reg.screen_flip};
            out_reg.pixel_y      <= b_cmd_reg.row;
            out_reg.pixel_color  <= sel2 ? c2 : c1;
            out_reg.last_of_item <= sel2 || !t2;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- design/pixel_blitter_with_flip_and_palette_top.sv -----
// Top level of the pixel blitter: walker, command queue and pixel engine.
// A command goes from the command queue through the pixel stage to the output register.
// Throughput: one source byte per cycle while the queue has space and no clear runs;
// a byte with two visible pixels sends both through the single output register in turn.
// Reset: a clearing pass writes zero to all 65536 work-memory words, one per cycle,
// with in_ready low until the pass ends; configuration writes are taken throughout.
module pixel_blitter_with_flip_and_palette_top
    import pblit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pblit_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pblit_out_t  out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    pblit_push_t push;
    pblit_cmd_t  head;
    logic        has_space, head_valid, pop, clearing;

    pblit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .space_ok  (has_space && !clearing),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    pblit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .has_space  (has_space),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pblit_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
